[hdl/assert_macros.svh]
// Assertion macros shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define GHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define GHA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/gha_pkg.sv]
// Shared types and constants of the generational handle allocator.
`timescale 1ns / 1ps

package gha_pkg;

  localparam int POOL_SLOTS_DEF = 64;
  localparam int GEN_BITS_DEF   = 16;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2,
    ST_STALE     = 2'd3
  } status_t;

  // Decision of the core for the request being finished.
  typedef struct packed {
    logic    tbl_we;
    logic    stk_we;
    status_t status;
  } core_ctl_t;

endpackage

[hdl/gha_ram.sv]
// Simple dual-port RAM with registered read and write-to-read bypass.
`timescale 1ns / 1ps

module gha_ram #(
  parameter int DEPTH = gha_pkg::POOL_SLOTS_DEF,
  parameter int WIDTH = gha_pkg::GEN_BITS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read in the same cycle as a write to that address sees the new data.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

[hdl/gha_core.sv]
// Allocate and release decision, free stack depth and used slot count.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module gha_core #(
  parameter int POOL_SLOTS = gha_pkg::POOL_SLOTS_DEF,
  parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF,
  localparam int IDX_W     = $clog2(POOL_SLOTS),
  localparam int CNT_W     = $clog2(POOL_SLOTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic                    op,
  input  logic [IDX_W-1:0]        idx,
  input  logic [GEN_BITS-1:0]     gen,
  input  logic [GEN_BITS:0]       tbl_rdata,   // {active, generation}
  input  logic [IDX_W+GEN_BITS-1:0] stk_rdata, // {generation, index}
  output gha_pkg::core_ctl_t      ctl,
  output logic [IDX_W-1:0]        tbl_waddr,
  output logic [GEN_BITS:0]       tbl_wdata,
  output logic [IDX_W-1:0]        stk_waddr,
  output logic [IDX_W+GEN_BITS-1:0] stk_wdata,
  output logic [IDX_W-1:0]        stk_raddr,
  output logic [IDX_W-1:0]        res_idx,
  output logic [GEN_BITS-1:0]     res_gen
);

  logic [CNT_W-1:0]    free_depth, free_depth_next;
  logic [CNT_W-1:0]    used_slots, used_slots_next;
  logic [GEN_BITS-1:0] gen_inc;
  logic [CNT_W-1:0]    stk_top;

  assign gen_inc = tbl_rdata[GEN_BITS-1:0] + GEN_BITS'(1);

  always_comb begin
    ctl             = '{tbl_we: 1'b0, stk_we: 1'b0, status: gha_pkg::ST_OK};
    free_depth_next = free_depth;
    used_slots_next = used_slots;
    tbl_waddr       = idx;
    tbl_wdata       = {1'b0, gen_inc};
    stk_waddr       = free_depth[IDX_W-1:0];
    stk_wdata       = {gen_inc, idx};
    res_idx         = '0;
    res_gen         = '0;
    if (op == gha_pkg::OP_ALLOC) begin
      if (free_depth != '0) begin
        // Reuse the most recently released slot; its generation rides on the stack.
        ctl.tbl_we      = 1'b1;
        free_depth_next = free_depth - CNT_W'(1);
        res_idx         = stk_rdata[IDX_W-1:0];
        res_gen         = stk_rdata[IDX_W+GEN_BITS-1:IDX_W];
      end else if (used_slots < CNT_W'(POOL_SLOTS)) begin
        // A fresh slot gets its generation written here, so no table clear is needed.
        ctl.tbl_we      = 1'b1;
        used_slots_next = used_slots + CNT_W'(1);
        res_idx         = used_slots[IDX_W-1:0];
        res_gen         = '0;
      end else begin
        ctl.status = gha_pkg::ST_EXHAUSTED;
      end
      tbl_waddr = res_idx;
      tbl_wdata = {1'b1, res_gen};
    end else begin
      if (CNT_W'(idx) >= used_slots) begin
        ctl.status = gha_pkg::ST_RANGE;
      end else if ((tbl_rdata[GEN_BITS-1:0] != gen) || !tbl_rdata[GEN_BITS] ||
                   (free_depth >= CNT_W'(POOL_SLOTS))) begin
        ctl.status = gha_pkg::ST_STALE;
      end else begin
        ctl.tbl_we      = 1'b1;
        ctl.stk_we      = 1'b1;
        free_depth_next = free_depth + CNT_W'(1);
      end
    end
    if (!go) begin
      ctl.tbl_we      = 1'b0;
      ctl.stk_we      = 1'b0;
      free_depth_next = free_depth;
      used_slots_next = used_slots;
    end
  end

  // Top of the stack as the next request will see it.
  assign stk_top   = free_depth_next - CNT_W'(1);
  assign stk_raddr = stk_top[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      free_depth <= '0;
      used_slots <= '0;
    end else begin
      free_depth <= free_depth_next;
      used_slots <= used_slots_next;
    end
  end

  `GHA_ASSERT(a_depth_le_used, free_depth <= used_slots, "free stack deeper than slots used")
  `GHA_ASSERT(a_used_le_pool, used_slots <= CNT_W'(POOL_SLOTS), "used slot count beyond pool")
  `GHA_ASSERT(a_push_grows, ctl.stk_we |=> (free_depth == $past(free_depth) + CNT_W'(1)),
              "push did not grow the free stack")
  `GHA_ASSERT(a_push_writes_table, ctl.stk_we |-> ctl.tbl_we,
              "release pushed without updating the slot")

endmodule

[hdl/generational_handle_allocator.sv]
// Top level of the generational handle allocator: stream ports and request pipeline.
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Each request (allocate or release) gives exactly one result, passing through the request
// register and then the output register, and a new request can be taken in every cycle
// while the output side is ready. The slot table and free stack are read at acceptance and
// updated when the core completes the request, with bypass so back-to-back requests see each
// other's updates. Slot generations are written when a slot is first handed out, so
// no clearing pass follows reset. Status on m_axis_tuser: 0 ok, 1 pool exhausted,
// 2 index out of range, 3 stale handle (also for a release of a slot already free).
module generational_handle_allocator #(
  parameter int POOL_SLOTS = gha_pkg::POOL_SLOTS_DEF,
  parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF,
  localparam int IDX_W     = $clog2(POOL_SLOTS),
  localparam int TD_W      = ((IDX_W + GEN_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [TD_W-1:0] s_axis_tdata,  // handle_index, handle_generation, zero pad
  input  logic            s_axis_tuser,  // op
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [TD_W-1:0] m_axis_tdata,  // slot_index, slot_generation, zero pad
  output logic [1:0]      m_axis_tuser   // status
);

  localparam int STK_W = IDX_W + GEN_BITS;

  logic                s1_valid;
  logic                s1_op;
  logic [IDX_W-1:0]    s1_idx;
  logic [GEN_BITS-1:0] s1_gen;
  logic                adv, go, accept;

  gha_pkg::core_ctl_t  ctl;
  logic [IDX_W-1:0]    tbl_waddr, stk_waddr, stk_raddr, res_idx;
  logic [GEN_BITS:0]   tbl_wdata, tbl_rdata;
  logic [STK_W-1:0]    stk_wdata, stk_rdata;
  logic [GEN_BITS-1:0] res_gen;

  logic [IDX_W-1:0]    out_idx;
  logic [GEN_BITS-1:0] out_gen;
  gha_pkg::status_t    out_status;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign go            = s1_valid && adv;
  assign s_axis_tready = !s1_valid || adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  gha_ram #(.DEPTH(POOL_SLOTS), .WIDTH(GEN_BITS + 1)) u_table (
    .clk  (clk),
    .we   (ctl.tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .re   (accept),
    .raddr(s_axis_tdata[IDX_W-1:0]),
    .rdata(tbl_rdata)
  );

  gha_ram #(.DEPTH(POOL_SLOTS), .WIDTH(STK_W)) u_stack (
    .clk  (clk),
    .we   (ctl.stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .re   (accept),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  gha_core #(.POOL_SLOTS(POOL_SLOTS), .GEN_BITS(GEN_BITS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .op       (s1_op),
    .idx      (s1_idx),
    .gen      (s1_gen),
    .tbl_rdata(tbl_rdata),
    .stk_rdata(stk_rdata),
    .ctl      (ctl),
    .tbl_waddr(tbl_waddr),
    .tbl_wdata(tbl_wdata),
    .stk_waddr(stk_waddr),
    .stk_wdata(stk_wdata),
    .stk_raddr(stk_raddr),
    .res_idx  (res_idx),
    .res_gen  (res_gen)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (go) begin
        s1_valid <= 1'b0;
      end
      if (go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op  <= s_axis_tuser;
      s1_idx <= s_axis_tdata[IDX_W-1:0];
      s1_gen <= s_axis_tdata[IDX_W+GEN_BITS-1:IDX_W];
    end
    if (go) begin
      out_status <= ctl.status;
      out_idx    <= res_idx;
      out_gen    <= res_gen;
    end
  end

  assign m_axis_tdata = TD_W'({out_gen, out_idx});
  assign m_axis_tuser = out_status;

  // With nothing waiting at the output the block must be able to take a transfer.
  `GHA_ASSERT(a_ready_when_out_empty, !m_axis_tvalid |-> s_axis_tready,
              "input stalled with an empty output register")

endmodule
